>>> hw/rtl/sorted_timer_queue_unit_assert.svh
// Assertion macros for the sorted timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_TIMER_QUEUE_UNIT_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define STQ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define STQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/stq_pkg.sv
// Types and constants shared by the sorted timer queue modules.
package stq_pkg;

	localparam int TIME_W    = 32;
	localparam int HDL_W     = 8;
	localparam int DROP_W    = 5;
	localparam int TOTAL_W   = 5;

	typedef enum logic [2:0] {
		CMD_INSERT     = 3'd0,
		CMD_REMOVE     = 3'd1,
		CMD_DROP       = 3'd2,
		CMD_QUERY      = 3'd3,
		CMD_REMOVE_HDL = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_RD,
		S_INS_EV,
		S_SRCH_RD,
		S_SRCH_EV,
		S_CMP_RD,
		S_CMP_EV,
		S_HEAD_RD,
		S_HEAD_EV,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		PTR_KEEP,
		PTR_ZERO,
		PTR_CNT,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		RA_PTR,
		RA_PTR_M1,
		RA_PTR_OFF,
		RA_HEAD
	} raddr_sel_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_INC,
		CNT_SUB
	} cnt_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		ptr_op_t    ptr_op;
		logic       off_one;
		logic       rd_en;
		raddr_sel_t ra_sel;
		logic       wr_en;
		logic       wr_new;
		cnt_op_t    cnt_op;
		logic       st_we;
		status_t    st_val;
		logic       found_set;
		logic       head_load;
		logic       out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic ptr_zero;
		logic scan_end;
		logic cmp_end;
		logic rd_gt;
		logic rd_exact;
		logic rd_hdl;
		logic out_free;
	} dp_stat_t;

endpackage

>>> hw/rtl/stq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/stq_dp.sv
// Datapath of the sorted timer queue: entry table, count, pointers and result registers.
`include "sorted_timer_queue_unit_assert.svh"

module stq_dp import stq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          cmd,
	input  logic [TIME_W-1:0]   event_time,
	input  logic [HDL_W-1:0]    handler_id,
	input  logic [DROP_W-1:0]   drop_count,
	input  dp_cmd_t             ctl,
	output dp_stat_t            stat,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [1:0]          status,
	output logic                found,
	output logic [TOTAL_W-1:0]  entry_total,
	output logic                head_valid,
	output logic [TIME_W-1:0]   head_time,
	output logic [HDL_W-1:0]    head_handler
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = TIME_W + HDL_W;

	cmd_t               cmd_q;
	logic [TIME_W-1:0]  time_q;
	logic [HDL_W-1:0]   hdl_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   off_q;
	status_t            st_q;
	logic               found_q;
	logic               head_vld_q;
	logic [TIME_W-1:0]  head_time_q;
	logic [HDL_W-1:0]   head_hdl_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic               out_found_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic               out_head_vld_q;
	logic [TIME_W-1:0]  out_head_time_q;
	logic [HDL_W-1:0]   out_head_hdl_q;

	logic [IDX_W-1:0]   ram_raddr;
	logic [ENT_W-1:0]   ram_wdata;
	logic [ENT_W-1:0]   ram_rdata;
	logic [TIME_W-1:0]  rd_time;
	logic [HDL_W-1:0]   rd_hdl;

	logic [CNT_W:0]     ptr_off;
	logic [CNT_W-1:0]   ptr_m1;
	logic [CNT_W+DROP_W-1:0]  drop_ext;
	logic [CNT_W+DROP_W-1:0]  cnt_ext;
	logic [CNT_W-1:0]   drop_clamp;
	logic [CNT_W+TOTAL_W-1:0] total_ext;

	assign rd_time = ram_rdata[ENT_W-1:HDL_W];
	assign rd_hdl  = ram_rdata[HDL_W-1:0];

	assign ptr_off = {1'b0, ptr_q} + {1'b0, off_q};
	assign ptr_m1  = ptr_q - CNT_W'(1);

	// The drop count is clamped to the number of entries held.
	assign drop_ext   = {{CNT_W{1'b0}}, drop_count};
	assign cnt_ext    = {{DROP_W{1'b0}}, cnt_q};
	assign drop_clamp = (drop_ext > cnt_ext) ? cnt_q : drop_ext[CNT_W-1:0];

	assign total_ext = {{TOTAL_W{1'b0}}, cnt_q};

	always_comb begin
		case (ctl.ra_sel)
			RA_PTR:     ram_raddr = ptr_q[IDX_W-1:0];
			RA_PTR_M1:  ram_raddr = ptr_m1[IDX_W-1:0];
			RA_PTR_OFF: ram_raddr = ptr_off[IDX_W-1:0];
			RA_HEAD:    ram_raddr = '0;
			default:    ram_raddr = '0;
		endcase
	end

	assign ram_wdata = ctl.wr_new ? {time_q, hdl_q} : ram_rdata;

	stq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ctl.wr_en),
		.waddr(ptr_q[IDX_W-1:0]),
		.wdata(ram_wdata),
		.re   (ctl.rd_en),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		stat.cmd      = cmd_q;
		stat.full     = (cnt_q == CNT_W'(DEPTH));
		stat.ptr_zero = (ptr_q == '0);
		stat.scan_end = (ptr_q >= cnt_q);
		stat.cmp_end  = (ptr_off >= {1'b0, cnt_q});
		stat.rd_gt    = (rd_time > time_q);
		stat.rd_exact = (rd_time == time_q) && (rd_hdl == hdl_q);
		stat.rd_hdl   = (rd_hdl == hdl_q);
		stat.out_free = !out_valid_q || !out_stall;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctl.cnt_op)
				CNT_INC:  cnt_q <= cnt_q + CNT_W'(1);
				CNT_SUB:  cnt_q <= cnt_q - off_q;
				default:  cnt_q <= cnt_q;
			endcase
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result payload.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_t'(cmd);
			time_q  <= event_time;
			hdl_q   <= handler_id;
			off_q   <= drop_clamp;
			st_q    <= ST_OK;
			found_q <= 1'b0;
		end else begin
			if (ctl.off_one) begin
				off_q <= CNT_W'(1);
			end
			if (ctl.st_we) begin
				st_q <= ctl.st_val;
			end
			if (ctl.found_set) begin
				found_q <= 1'b1;
			end
		end
		case (ctl.ptr_op)
			PTR_ZERO: ptr_q <= '0;
			PTR_CNT:  ptr_q <= cnt_q;
			PTR_INC:  ptr_q <= ptr_q + CNT_W'(1);
			PTR_DEC:  ptr_q <= ptr_m1;
			default:  ptr_q <= ptr_q;
		endcase
		if (ctl.head_load) begin
			head_vld_q  <= (cnt_q != '0);
			head_time_q <= (cnt_q != '0) ? rd_time : '0;
			head_hdl_q  <= (cnt_q != '0) ? rd_hdl : '0;
		end
		if (ctl.out_load) begin
			out_status_q    <= st_q;
			out_found_q     <= found_q;
			out_total_q     <= total_ext[TOTAL_W-1:0];
			out_head_vld_q  <= head_vld_q;
			out_head_time_q <= head_time_q;
			out_head_hdl_q  <= head_hdl_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign found        = out_found_q;
	assign entry_total  = out_total_q;
	assign head_valid   = out_head_vld_q;
	assign head_time    = out_head_time_q;
	assign head_handler = out_head_hdl_q;

	`STQ_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
	`STQ_ASSERT_IMPLY(a_ins_room, clk, arst_n, ctl.cnt_op == CNT_INC, cnt_q != CNT_W'(DEPTH), "insert into full table")
	`STQ_ASSERT_IMPLY(a_sub_bound, clk, arst_n, ctl.cnt_op == CNT_SUB, off_q <= cnt_q, "removal exceeds count")
	`STQ_ASSERT_IMPLY(a_out_free, clk, arst_n, ctl.out_load, !out_valid_q || !out_stall, "result overwritten")

endmodule

>>> hw/rtl/stq_ctrl.sv
// Controller state machine of the sorted timer queue.
module stq_ctrl import stq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  ctl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		ctl           = '0;
		ctl.ptr_op    = PTR_KEEP;
		ctl.ra_sel    = RA_PTR;
		ctl.cnt_op    = CNT_KEEP;
		ctl.st_val    = ST_OK;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) begin
							ctl.st_we  = 1'b1;
							ctl.st_val = ST_FULL;
							state_d    = S_HEAD_RD;
						end else begin
							ctl.ptr_op = PTR_CNT;
							state_d    = S_INS_RD;
						end
					end
					CMD_REMOVE, CMD_QUERY, CMD_REMOVE_HDL: begin
						ctl.ptr_op = PTR_ZERO;
						state_d    = S_SRCH_RD;
					end
					CMD_DROP: begin
						ctl.ptr_op = PTR_ZERO;
						state_d    = S_CMP_RD;
					end
					default: begin
						state_d = S_HEAD_RD;
					end
				endcase
			end
			// Insert walks down from the tail, moving later entries up one slot.
			S_INS_RD: begin
				if (stat.ptr_zero) begin
					ctl.wr_en  = 1'b1;
					ctl.wr_new = 1'b1;
					ctl.cnt_op = CNT_INC;
					state_d    = S_HEAD_RD;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.ra_sel = RA_PTR_M1;
					state_d    = S_INS_EV;
				end
			end
			S_INS_EV: begin
				ctl.wr_en = 1'b1;
				if (stat.rd_gt) begin
					ctl.ptr_op = PTR_DEC;
					state_d    = S_INS_RD;
				end else begin
					ctl.wr_new = 1'b1;
					ctl.cnt_op = CNT_INC;
					state_d    = S_HEAD_RD;
				end
			end
			S_SRCH_RD: begin
				if (stat.scan_end) begin
					ctl.st_we  = 1'b1;
					ctl.st_val = ST_NOT_FOUND;
					state_d    = S_HEAD_RD;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.ra_sel = RA_PTR;
					state_d    = S_SRCH_EV;
				end
			end
			S_SRCH_EV: begin
				if (stat.cmd == CMD_REMOVE) begin
					if (stat.rd_exact) begin
						ctl.found_set = 1'b1;
						ctl.off_one   = 1'b1;
						state_d       = S_CMP_RD;
					end else if (stat.rd_gt) begin
						// The list is sorted, so no later entry can match.
						ctl.st_we  = 1'b1;
						ctl.st_val = ST_NOT_FOUND;
						state_d    = S_HEAD_RD;
					end else begin
						ctl.ptr_op = PTR_INC;
						state_d    = S_SRCH_RD;
					end
				end else if (stat.rd_hdl) begin
					ctl.found_set = 1'b1;
					if (stat.cmd == CMD_REMOVE_HDL) begin
						ctl.off_one = 1'b1;
						state_d     = S_CMP_RD;
					end else begin
						state_d = S_HEAD_RD;
					end
				end else begin
					ctl.ptr_op = PTR_INC;
					state_d    = S_SRCH_RD;
				end
			end
			// Compaction copies each entry down by the offset, then shrinks the count.
			S_CMP_RD: begin
				if (stat.cmp_end) begin
					ctl.cnt_op = CNT_SUB;
					state_d    = S_HEAD_RD;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.ra_sel = RA_PTR_OFF;
					state_d    = S_CMP_EV;
				end
			end
			S_CMP_EV: begin
				ctl.wr_en  = 1'b1;
				ctl.ptr_op = PTR_INC;
				state_d    = S_CMP_RD;
			end
			S_HEAD_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.ra_sel = RA_HEAD;
				state_d    = S_HEAD_EV;
			end
			S_HEAD_EV: begin
				ctl.head_load = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/sorted_timer_queue_unit.sv
// Top level of the sorted timer queue: controller and datapath.
//
//  channel   handshake               payload
//  request   in_valid / in_stall     cmd, event_time, handler_id, drop_count
//  result    out_valid / out_stall   status, found, entry_total, head_valid,
//                                    head_time, head_handler
//
// One request is worked at a time. Every table slot that is scanned or moved takes a
// read on the table RAM (one write port, one read port; address, then registered data),
// and a request also passes accept, dispatch, head read and result load. Reset empties
// the table at once, with no clearing pass. The result sits in an output register; a
// stalled result holds there while the next request is already accepted and worked.
module sorted_timer_queue_unit import stq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [TIME_W-1:0]  event_time,
	input  logic [HDL_W-1:0]   handler_id,
	input  logic [DROP_W-1:0]  drop_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               found,
	output logic [TOTAL_W-1:0] entry_total,
	output logic               head_valid,
	output logic [TIME_W-1:0]  head_time,
	output logic [HDL_W-1:0]   head_handler
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	stq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.ctl     (ctl)
	);

	stq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.event_time  (event_time),
		.handler_id  (handler_id),
		.drop_count  (drop_count),
		.ctl         (ctl),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.found       (found),
		.entry_total (entry_total),
		.head_valid  (head_valid),
		.head_time   (head_time),
		.head_handler(head_handler)
	);

endmodule
